### hw/rtl/lp2sc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lp2sc_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE           = 3'd0,
    ERR_CUT_LENGTH     = 3'd1,
    ERR_NAL_PAST_END   = 3'd2,
    ERR_NEG_SIZE       = 3'd3,
    ERR_RECORD_CUT     = 3'd4,
    ERR_STORE_OVERFLOW = 3'd5
  } err_t;

  // What one accepted request produces, in output order.
  typedef struct packed {
    logic put_en;
    logic ps_en;
    logic sc_en;
    logic sc_four;
    logic data_en;
    logic stat_en;
  } plan_t;

  typedef struct packed {
    logic accept;
    logic put_step;
    logic ps_emit;
    logic sc_emit;
    logic data_emit;
    logic stat_emit;
  } cmd_t;

  typedef struct packed {
    plan_t plan_next;
    plan_t plan;
    logic  out_free;
    logic  put_done;
    logic  ps_done;
    logic  sc_done;
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/lp2sc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lp2sc_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  output lp2sc_pkg::cmd_t      cmd,
  input  lp2sc_pkg::stat_t     st
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PUT  = 7'b0000010,
    ST_PSRD = 7'b0000100,
    ST_PS   = 7'b0001000,
    ST_SC   = 7'b0010000,
    ST_DATA = 7'b0100000,
    ST_STAT = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  function automatic state_t after_data(input lp2sc_pkg::plan_t p);
    after_data = p.stat_en ? ST_STAT : ST_IDLE;
  endfunction

  function automatic state_t after_sc(input lp2sc_pkg::plan_t p);
    after_sc = p.data_en ? ST_DATA : after_data(p);
  endfunction

  function automatic state_t after_ps(input lp2sc_pkg::plan_t p);
    after_ps = p.sc_en ? ST_SC : after_sc(p);
  endfunction

  function automatic state_t first_step(input lp2sc_pkg::plan_t p);
    if (p.put_en) begin
      first_step = ST_PUT;
    end else if (p.ps_en) begin
      first_step = ST_PSRD;
    end else begin
      first_step = after_ps(p);
    end
  endfunction

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = first_step(st.plan_next);
        end
      end
      ST_PUT: begin
        cmd.put_step = 1'b1;
        if (st.put_done) begin
          state_next = after_ps(st.plan);
        end
      end
      ST_PSRD: begin
        state_next = ST_PS;
      end
      ST_PS: begin
        if (st.out_free) begin
          cmd.ps_emit = 1'b1;
          state_next  = st.ps_done ? after_ps(st.plan) : ST_PSRD;
        end
      end
      ST_SC: begin
        if (st.out_free) begin
          cmd.sc_emit = 1'b1;
          if (st.sc_done) begin
            state_next = after_sc(st.plan);
          end
        end
      end
      ST_DATA: begin
        if (st.out_free) begin
          cmd.data_emit = 1'b1;
          state_next    = after_data(st.plan);
        end
      end
      ST_STAT: begin
        if (st.out_free) begin
          cmd.stat_emit = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lp2sc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module lp2sc_dpath #(
  parameter int PS_BYTES = 48
) (
  input  wire               clk,
  input  wire               rst,
  input  lp2sc_pkg::cmd_t   cmd,
  output lp2sc_pkg::stat_t  st,
  input  wire  [7:0]        s_tdata,
  input  wire               s_tuser,
  input  wire               s_tlast,
  output logic              m_tvalid,
  input  wire               m_tready,
  output logic [15:0]       m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);

  localparam int AW = $clog2(PS_BYTES);
  localparam int LW = $clog2(PS_BYTES + 1);

  typedef enum logic [2:0] {
    RP_HEADER    = 3'd0,
    RP_SPS_COUNT = 3'd1,
    RP_SIZE_HI   = 3'd2,
    RP_SIZE_LO   = 3'd3,
    RP_DATA      = 3'd4,
    RP_PPS_COUNT = 3'd5,
    RP_DONE      = 3'd6,
    RP_FAILED    = 3'd7
  } rphase_t;

  typedef enum logic [1:0] {
    PP_LENGTH = 2'd0,
    PP_HEAD   = 2'd1,
    PP_BODY   = 2'd2,
    PP_SPARE  = 2'd3
  } pphase_t;

  logic [LW-1:0]    len, len_next;
  rphase_t          rphase, rphase_next;
  logic [2:0]       ridx, ridx_next;
  logic [7:0]       units_left, units_left_next;
  logic [15:0]      ubl, ubl_next;
  logic             pps_read, pps_read_next;
  pphase_t          pphase, pphase_next;
  logic [1:0]       lbc, lbc_next;
  logic [31:0]      acc, acc_next;
  logic [30:0]      nbl, nbl_next;
  logic             first_nal, first_nal_next;
  logic             drop, drop_next;

  lp2sc_pkg::plan_t plan, plan_next;
  lp2sc_pkg::kind_t stat_kind, stat_kind_next;
  lp2sc_pkg::err_t  stat_err, stat_err_next;
  logic [7:0]       data_byte;
  logic [LW-1:0]    put_base, put_base_next;
  logic [1:0]       put_idx;
  logic [AW-1:0]    ps_idx;
  logic [1:0]       sc_idx;
  logic [7:0]       rd_data;
  logic [7:0]       mem [PS_BYTES];

  logic             rec_wr;
  logic             rec_err;
  logic             pkt_err;
  logic [15:0]      ubl_lo;
  logic [16:0]      fill_sum;
  logic [31:0]      acc_shift;

  logic             mem_we;
  logic [LW-1:0]    put_addr;
  logic [AW-1:0]    mem_addr;
  logic [7:0]       mem_wdata;
  logic [LW-1:0]    len_m1;

  logic [7:0]       o_byte;
  lp2sc_pkg::err_t  o_err;
  lp2sc_pkg::kind_t o_kind;

  function automatic rphase_t next_unit(input logic [7:0] left, input logic pps);
    if (left != 8'd0) begin
      next_unit = RP_SIZE_HI;
    end else if (!pps) begin
      next_unit = RP_PPS_COUNT;
    end else begin
      next_unit = RP_DONE;
    end
  endfunction

  always_comb begin
    len_next        = len;
    rphase_next     = rphase;
    ridx_next       = ridx;
    units_left_next = units_left;
    ubl_next        = ubl;
    pps_read_next   = pps_read;
    pphase_next     = pphase;
    lbc_next        = lbc;
    acc_next        = acc;
    nbl_next        = nbl;
    first_nal_next  = first_nal;
    drop_next       = drop;
    plan_next       = '0;
    stat_kind_next  = lp2sc_pkg::KIND_BYTE;
    stat_err_next   = lp2sc_pkg::ERR_NONE;
    put_base_next   = put_base;
    rec_wr          = 1'b0;
    rec_err         = 1'b0;
    pkt_err         = 1'b0;
    ubl_lo          = ubl | {8'h00, s_tdata};
    fill_sum        = 17'(len) + 17'd4 + 17'(ubl_lo);
    acc_shift       = {acc[23:0], s_tdata};

    if (s_tuser) begin
      case (rphase)
        RP_HEADER: begin
          if (ridx == 3'd0) begin
            len_next = '0;
          end
          if (ridx == 3'd4) begin
            ridx_next   = 3'd0;
            rphase_next = RP_SPS_COUNT;
          end else begin
            ridx_next = ridx + 3'd1;
          end
        end
        RP_SPS_COUNT: begin
          units_left_next = {3'b000, s_tdata[4:0]};
          rphase_next     = next_unit({3'b000, s_tdata[4:0]}, pps_read);
        end
        RP_PPS_COUNT: begin
          units_left_next = s_tdata;
          pps_read_next   = 1'b1;
          rphase_next     = next_unit(s_tdata, 1'b1);
        end
        RP_SIZE_HI: begin
          ubl_next    = {s_tdata, 8'h00};
          rphase_next = RP_SIZE_LO;
        end
        RP_SIZE_LO: begin
          ubl_next = ubl_lo;
          if (fill_sum > 17'(PS_BYTES)) begin
            rec_err = 1'b1;
          end else begin
            plan_next.put_en = 1'b1;
            put_base_next    = len;
            len_next         = len + LW'(4);
            if (ubl_lo == 16'd0) begin
              units_left_next = units_left - 8'd1;
              rphase_next     = next_unit(units_left - 8'd1, pps_read);
            end else begin
              rphase_next = RP_DATA;
            end
          end
        end
        RP_DATA: begin
          rec_wr   = 1'b1;
          len_next = len + LW'(1);
          ubl_next = ubl - 16'd1;
          if (ubl == 16'd1) begin
            units_left_next = units_left - 8'd1;
            rphase_next     = next_unit(units_left - 8'd1, pps_read);
          end
        end
        default: begin
        end
      endcase

      if (rec_err) begin
        len_next          = '0;
        rphase_next       = RP_FAILED;
        plan_next.stat_en = 1'b1;
        stat_kind_next    = lp2sc_pkg::KIND_ERR;
        stat_err_next     = lp2sc_pkg::ERR_STORE_OVERFLOW;
      end else if (s_tlast) begin
        if (rphase_next == RP_DONE) begin
          plan_next.stat_en = 1'b1;
          stat_kind_next    = lp2sc_pkg::KIND_OK;
        end else if (rphase_next != RP_FAILED) begin
          len_next          = '0;
          plan_next.stat_en = 1'b1;
          stat_kind_next    = lp2sc_pkg::KIND_ERR;
          stat_err_next     = lp2sc_pkg::ERR_RECORD_CUT;
        end
      end
      if (s_tlast) begin
        rphase_next     = RP_HEADER;
        ridx_next       = 3'd0;
        units_left_next = 8'd0;
        ubl_next        = 16'd0;
        pps_read_next   = 1'b0;
      end
    end else if (drop) begin
      if (s_tlast) begin
        pphase_next    = PP_LENGTH;
        lbc_next       = 2'd0;
        acc_next       = 32'd0;
        nbl_next       = 31'd0;
        first_nal_next = 1'b1;
        drop_next      = 1'b0;
      end
    end else begin
      case (pphase)
        PP_LENGTH: begin
          if (lbc == 2'd3) begin
            lbc_next = 2'd0;
            acc_next = 32'd0;
            if (acc_shift[31]) begin
              pkt_err = 1'b1;
            end else begin
              nbl_next = acc_shift[30:0];
              if (acc_shift[30:0] == 31'd0) begin
                plan_next.sc_en   = 1'b1;
                plan_next.sc_four = first_nal;
                first_nal_next    = 1'b0;
              end else begin
                pphase_next = PP_HEAD;
              end
            end
          end else begin
            lbc_next = lbc + 2'd1;
            acc_next = acc_shift;
          end
        end
        PP_HEAD: begin
          plan_next.ps_en   = (s_tdata[4:0] == 5'd5) && (len != '0);
          plan_next.sc_en   = 1'b1;
          plan_next.sc_four = first_nal;
          plan_next.data_en = 1'b1;
          first_nal_next    = 1'b0;
          nbl_next          = nbl - 31'd1;
          pphase_next       = (nbl == 31'd1) ? PP_LENGTH : PP_BODY;
        end
        PP_BODY: begin
          plan_next.data_en = 1'b1;
          nbl_next          = nbl - 31'd1;
          if (nbl == 31'd1) begin
            pphase_next = PP_LENGTH;
          end
        end
        default: begin
          pphase_next = PP_LENGTH;
        end
      endcase

      if (pkt_err) begin
        drop_next         = 1'b1;
        plan_next.stat_en = 1'b1;
        stat_kind_next    = lp2sc_pkg::KIND_ERR;
        stat_err_next     = lp2sc_pkg::ERR_NEG_SIZE;
      end else if (s_tlast) begin
        plan_next.stat_en = 1'b1;
        if (pphase_next == PP_LENGTH && lbc_next == 2'd0) begin
          stat_kind_next = lp2sc_pkg::KIND_OK;
        end else if (pphase_next == PP_LENGTH) begin
          stat_kind_next = lp2sc_pkg::KIND_ERR;
          stat_err_next  = lp2sc_pkg::ERR_CUT_LENGTH;
        end else begin
          stat_kind_next = lp2sc_pkg::KIND_ERR;
          stat_err_next  = lp2sc_pkg::ERR_NAL_PAST_END;
        end
      end
      if (s_tlast) begin
        pphase_next    = PP_LENGTH;
        lbc_next       = 2'd0;
        acc_next       = 32'd0;
        nbl_next       = 31'd0;
        first_nal_next = 1'b1;
        drop_next      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len        <= '0;
      rphase     <= RP_HEADER;
      ridx       <= 3'd0;
      units_left <= 8'd0;
      ubl        <= 16'd0;
      pps_read   <= 1'b0;
      pphase     <= PP_LENGTH;
      lbc        <= 2'd0;
      acc        <= 32'd0;
      nbl        <= 31'd0;
      first_nal  <= 1'b1;
      drop       <= 1'b0;
      plan       <= '0;
      put_idx    <= 2'd0;
      ps_idx     <= '0;
      sc_idx     <= 2'd0;
    end else if (cmd.accept) begin
      len        <= len_next;
      rphase     <= rphase_next;
      ridx       <= ridx_next;
      units_left <= units_left_next;
      ubl        <= ubl_next;
      pps_read   <= pps_read_next;
      pphase     <= pphase_next;
      lbc        <= lbc_next;
      acc        <= acc_next;
      nbl        <= nbl_next;
      first_nal  <= first_nal_next;
      drop       <= drop_next;
      plan       <= plan_next;
      put_idx    <= 2'd0;
      ps_idx     <= '0;
      sc_idx     <= 2'd0;
    end else begin
      if (cmd.put_step) begin
        put_idx <= put_idx + 2'd1;
      end
      if (cmd.ps_emit) begin
        ps_idx <= ps_idx + AW'(1);
      end
      if (cmd.sc_emit) begin
        sc_idx <= sc_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      stat_kind <= stat_kind_next;
      stat_err  <= stat_err_next;
      data_byte <= s_tdata;
      put_base  <= put_base_next;
    end
  end

  // The start code in front of each stored unit is written one byte a cycle.
  assign put_addr  = put_base + {{(LW-2){1'b0}}, put_idx};
  assign mem_we    = cmd.put_step || (cmd.accept && rec_wr);
  assign mem_addr  = cmd.put_step ? put_addr[AW-1:0] : len[AW-1:0];
  assign mem_wdata = cmd.put_step ? ((put_idx == 2'd3) ? 8'h01 : 8'h00) : s_tdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[ps_idx];
  end

  assign len_m1 = len - LW'(1);

  assign st.plan_next = plan_next;
  assign st.plan      = plan;
  assign st.out_free  = !m_tvalid || m_tready;
  assign st.put_done  = (put_idx == 2'd3);
  assign st.ps_done   = (LW'(ps_idx) == len_m1);
  assign st.sc_done   = (sc_idx == (plan.sc_four ? 2'd3 : 2'd2));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.ps_emit || cmd.sc_emit || cmd.data_emit || cmd.stat_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ps_emit) begin
      o_byte  <= rd_data;
      o_kind  <= lp2sc_pkg::KIND_BYTE;
      o_err   <= lp2sc_pkg::ERR_NONE;
      m_tlast <= 1'b0;
    end else if (cmd.sc_emit) begin
      o_byte  <= st.sc_done ? 8'h01 : 8'h00;
      o_kind  <= lp2sc_pkg::KIND_BYTE;
      o_err   <= lp2sc_pkg::ERR_NONE;
      m_tlast <= st.sc_done && !plan.data_en && !plan.stat_en;
    end else if (cmd.data_emit) begin
      o_byte  <= data_byte;
      o_kind  <= lp2sc_pkg::KIND_BYTE;
      o_err   <= lp2sc_pkg::ERR_NONE;
      m_tlast <= !plan.stat_en;
    end else if (cmd.stat_emit) begin
      o_byte  <= 8'h00;
      o_kind  <= stat_kind;
      o_err   <= stat_err;
      m_tlast <= 1'b1;
    end
  end

  assign m_tdata = {5'b00000, o_err, o_byte};
  assign m_tuser = o_kind;

endmodule

`default_nettype wire

### hw/rtl/h264_length_prefix_to_start_code.sv
// A byte that produces no result is taken while idle; ready stays high.
// A stream byte is taken in the request cycle and sent from the data state.
// Start codes add three or four bytes, stored parameter sets a read and an
// emit state per byte (registered store read), a size byte four store writes.
// Reset is synchronous: parsing state clears, the store reads as empty, and
// the store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module h264_length_prefix_to_start_code #(
  parameter int PS_BYTES = 48
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] in_byte
  input  wire         s_tuser,   // [0] action
  input  wire         s_tlast,
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] error_code, [15:11] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  lp2sc_pkg::cmd_t  cmd;
  lp2sc_pkg::stat_t st;

  lp2sc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .st       (st)
  );

  lp2sc_dpath #(
    .PS_BYTES (PS_BYTES)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

### hw/rtl/lp2sc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lp2sc_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire [7:0]  s_tdata,
  input wire        s_tuser,
  input wire        s_tlast,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [15:0] m_tdata,
  input wire [1:0]  m_tuser,
  input wire        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output request changed while stalled");

  a_err_code_only_on_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != lp2sc_pkg::KIND_ERR |-> m_tdata[10:8] == lp2sc_pkg::ERR_NONE)
    else $error("error code set on a non-error result");

  a_error_has_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == lp2sc_pkg::KIND_ERR |-> m_tdata[10:8] != lp2sc_pkg::ERR_NONE)
    else $error("error result without a code");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != lp2sc_pkg::KIND_BYTE |-> m_tlast && m_tdata[7:0] == 8'h00)
    else $error("status result not last or carries a byte");

endmodule

bind h264_length_prefix_to_start_code lp2sc_checker u_lp2sc_checker (.*);

`default_nettype wire
